// ===== hw/rtl/lav_pkg.sv =====
// shared types, constants and rounding helper for the look-at view matrix block
package lav_pkg;

    localparam int FRAC_W = 30;
    localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
    localparam logic signed [33:0] SHIFT_MAX = 34'sh1_FFFF_FFFF;
    localparam logic signed [33:0] SHIFT_MIN = 34'sh2_0000_0000;
    localparam logic [33:0]        SHIFT_LIM = 34'h2_0000_0000;

    // three-component vector, x in the lowest bits
    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec32_t;

    typedef struct packed {
        logic signed [63:0] z;
        logic signed [63:0] y;
        logic signed [63:0] x;
    } vec64_t;

    // magnitude of v divided by 2^30, rounded half up (v never reaches -2^63)
    function automatic logic [33:0] round_mag(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] t;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            t = m + 64'h2000_0000;
            return t[63:30];
        end
    endfunction

endpackage

// ===== hw/rtl/look_at_view_matrix.sv =====
// Right-handed look-at view matrix, fully pipelined. One eye/target/up
// transaction is taken per clock and the three matrix rows leave in the same
// order; a stall on the output side freezes the whole pipeline. The path runs
// through the two normalizers, each a 32-stage square root followed by three
// 31-stage dividers, and through the cross products and the translation stages.
// If eye equals target or up is zero or parallel to the view direction, the
// identity rotation with zero translation is given.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_x, right_y, right_z, right_shift, upaxis_x, upaxis_y, upaxis_z,
    // upaxis_shift, back_x, back_y, back_z, back_shift, 2 zero bits
    output logic [391:0] m_axis_tdata
);

    logic               en;
    vec32_t             in_eye, in_tgt, in_up;

    logic               t0_valid_reg;
    vec32_t             t0_eye_reg, t0_up_reg;
    logic signed [32:0] t0_d_reg [3];

    logic               n1_valid, n1_zero;
    vec32_t             n1_vec;
    logic [191:0]       n1_side;

    logic               c1_valid;
    vec64_t             c1_vec;
    logic [192:0]       c1_side;

    logic               n2_valid, n2_zero;
    vec32_t             n2_vec;
    logic [192:0]       n2_side;

    logic               c2_valid;
    vec64_t             c2_vec;
    logic [288:0]       c2_side;

    logic signed [63:0] c2_comp [3];
    logic signed [31:0] ya_next [3];
    logic [33:0]        ya_mag [3];
    logic               t1_valid_reg;
    vec32_t             t1_ya_reg;
    logic [288:0]       t1_side_reg;

    logic               x_valid;
    logic signed [33:0] x_tx, x_ty, x_tz;
    logic [288:0]       x_side;
    logic               x_zero;

    logic               m_valid_reg;
    vec32_t             out_right_reg, out_up_reg, out_back_reg;
    logic signed [33:0] out_rs_reg, out_us_reg, out_bs_reg;

    // whole pipeline advances unless a result is stuck at the output
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign in_eye = s_axis_tdata[95:0];
    assign in_tgt = s_axis_tdata[191:96];
    assign in_up  = s_axis_tdata[287:192];

    // input stage: view direction eye - target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_valid_reg <= 1'b0;
        else if (en)
            t0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_eye_reg  <= in_eye;
            t0_up_reg   <= in_up;
            t0_d_reg[0] <= 33'(in_eye.x) - 33'(in_tgt.x);
            t0_d_reg[1] <= 33'(in_eye.y) - 33'(in_tgt.y);
            t0_d_reg[2] <= 33'(in_eye.z) - 33'(in_tgt.z);
        end
    end

    // back axis
    lav_norm #(.W(33), .SW(192)) u_norm_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t0_valid_reg),
        .in_x      (t0_d_reg[0]),
        .in_y      (t0_d_reg[1]),
        .in_z      (t0_d_reg[2]),
        .in_side   ({t0_up_reg, t0_eye_reg}),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    // up x back
    lav_cross #(.SW(193)) u_cross_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n1_valid),
        .a         (vec32_t'(n1_side[191:96])),
        .b         (n1_vec),
        .in_side   ({n1_zero, n1_vec, n1_side[95:0]}),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    // right axis
    lav_norm #(.W(64), .SW(193)) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .in_x      (c1_vec.x),
        .in_y      (c1_vec.y),
        .in_z      (c1_vec.z),
        .in_side   (c1_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    // back x right
    lav_cross #(.SW(289)) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .a         (vec32_t'(n2_side[191:96])),
        .b         (n2_vec),
        .in_side   ({n2_side[192] || n2_zero, n2_vec, n2_side[191:0]}),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    // up axis: round to q1.30 and clamp to +-1
    assign c2_comp[0] = c2_vec.x;
    assign c2_comp[1] = c2_vec.y;
    assign c2_comp[2] = c2_vec.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ya_mag[i] = round_mag(c2_comp[i]);
            if (ya_mag[i] > 34'(ONE_Q30))
                ya_mag[i] = 34'(ONE_Q30);
            ya_next[i] = c2_comp[i][63] ? -$signed(ya_mag[i][31:0])
                                        : $signed(ya_mag[i][31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1_valid_reg <= 1'b0;
        else if (en)
            t1_valid_reg <= c2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_ya_reg.x <= ya_next[0];
            t1_ya_reg.y <= ya_next[1];
            t1_ya_reg.z <= ya_next[2];
            t1_side_reg <= c2_side;
        end
    end

    // translations
    lav_xlate #(.SW(289)) u_xlate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t1_valid_reg),
        .ax        (vec32_t'(t1_side_reg[287:192])),
        .ay        (t1_ya_reg),
        .az        (vec32_t'(t1_side_reg[191:96])),
        .eye       (vec32_t'(t1_side_reg[95:0])),
        .in_side   ({t1_side_reg[288], t1_side_reg[287:192], t1_ya_reg,
                     t1_side_reg[191:96]}),
        .out_valid (x_valid),
        .out_tx    (x_tx),
        .out_ty    (x_ty),
        .out_tz    (x_tz),
        .out_side  (x_side)
    );

    assign x_zero = x_side[288];

    // output register, identity on zero length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= x_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_zero)
            begin
                out_right_reg <= {32'sd0, 32'sd0, ONE_Q30};
                out_up_reg    <= {32'sd0, ONE_Q30, 32'sd0};
                out_back_reg  <= {ONE_Q30, 32'sd0, 32'sd0};
                out_rs_reg    <= '0;
                out_us_reg    <= '0;
                out_bs_reg    <= '0;
            end
            else
            begin
                out_right_reg <= x_side[287:192];
                out_up_reg    <= x_side[191:96];
                out_back_reg  <= x_side[95:0];
                out_rs_reg    <= x_tx;
                out_us_reg    <= x_ty;
                out_bs_reg    <= x_tz;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_bs_reg, out_back_reg,
                            out_us_reg, out_up_reg,
                            out_rs_reg, out_right_reg};

`ifndef NO_ASSERTIONS
    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_right_reg.x <= ONE_Q30 && out_right_reg.x >= -ONE_Q30 &&
                           out_right_reg.y <= ONE_Q30 && out_right_reg.y >= -ONE_Q30 &&
                           out_right_reg.z <= ONE_Q30 && out_right_reg.z >= -ONE_Q30))
        else $error("right axis out of range");

    a_up_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_up_reg.x <= ONE_Q30 && out_up_reg.x >= -ONE_Q30 &&
                           out_up_reg.y <= ONE_Q30 && out_up_reg.y >= -ONE_Q30 &&
                           out_up_reg.z <= ONE_Q30 && out_up_reg.z >= -ONE_Q30))
        else $error("up axis out of range");

    a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_back_reg.x <= ONE_Q30 && out_back_reg.x >= -ONE_Q30 &&
                           out_back_reg.y <= ONE_Q30 && out_back_reg.y >= -ONE_Q30 &&
                           out_back_reg.z <= ONE_Q30 && out_back_reg.z >= -ONE_Q30))
        else $error("back axis out of range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");
`endif

endmodule

// ===== hw/rtl/lav_norm.sv =====
// pipelined vector normalizer: scale, sum of squares, square root, three dividers
module lav_norm
    import lav_pkg::*;
#(
    parameter int W  = 33,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    input  logic signed [W-1:0] in_z,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output vec32_t              out_vec,
    output logic                out_zero,
    output logic [SW-1:0]       out_side
);

    localparam int PW  = $clog2(W);
    localparam int NSQ = 32;
    localparam int NDV = 31;
    localparam int NS  = 4 + (NSQ + 1) + (NDV + 1) + 1;
    localparam int MW  = SW + 4;
    localparam int RW  = 36;
    localparam int DW  = 33;

    logic signed [W-1:0] in_v [3];
    logic [W-1:0]        in_mag [3];
    logic [2:0]          in_neg;
    logic                in_zero;

    logic [NS-1:0]       valid_reg;
    logic [MW-1:0]       meta_reg [NS];

    logic [W-1:0]        mag0_reg [3];
    logic [W-1:0]        orv0_reg;
    logic [PW-1:0]       lead;
    logic [PW-1:0]       p1_reg;
    logic [W-1:0]        mag1_reg [3];
    logic [30:0]         sm_next [3];
    logic [30:0]         sm2_reg [3];
    logic [61:0]         sq3_reg [3];
    logic [30:0]         sm3_reg [3];

    logic [63:0]         sq_s_reg    [NSQ+1];
    logic [RW-1:0]       sq_rem_reg  [NSQ+1];
    logic [31:0]         sq_root_reg [NSQ+1];
    logic [30:0]         sq_sm_reg   [NSQ+1][3];
    logic [63:0]         sq_s_next    [NSQ];
    logic [RW-1:0]       sq_rem_next  [NSQ];
    logic [31:0]         sq_root_next [NSQ];

    logic [DW-1:0]       dv_rem_reg [NDV+1][3];
    logic [30:0]         dv_q_reg   [NDV+1][3];
    logic [30:0]         dv_low_reg [NDV+1][3];
    logic [31:0]         dv_len_reg [NDV+1];
    logic [DW-1:0]       dv_rem_next [NDV][3];
    logic [30:0]         dv_q_next   [NDV][3];
    logic [61:0]         num [3];

    logic signed [31:0]  res_reg [3];
    logic [2:0]          fin_neg;

    assign in_v[0] = in_x;
    assign in_v[1] = in_y;
    assign in_v[2] = in_z;

    // magnitudes and signs at the input
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_neg[i] = in_v[i][W-1];
            in_mag[i] = in_v[i][W-1] ? W'(-in_v[i]) : W'(in_v[i]);
        end
        in_zero = (in_x == '0) && (in_y == '0) && (in_z == '0);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    // side data, signs and zero flag travel with the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= {in_side, in_neg, in_zero};
            for (int k = 1; k < NS; k++)
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    // leading one of the combined magnitudes
    always_comb
    begin
        lead = '0;
        for (int b = 0; b < W; b++)
            if (orv0_reg[b])
                lead = PW'(b);
    end

    // scale so that the largest magnitude sits in [2^30, 2^31)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (p1_reg >= PW'(FRAC_W))
                sm_next[i] = 31'(mag1_reg[i] >> (p1_reg - PW'(FRAC_W)));
            else
                sm_next[i] = 31'(mag1_reg[i] << (PW'(FRAC_W) - p1_reg));
        end
    end

    // front stages: magnitude, lead detect, scale, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg <= in_mag;
            orv0_reg <= in_mag[0] | in_mag[1] | in_mag[2];
            p1_reg   <= lead;
            mag1_reg <= mag0_reg;
            sm2_reg  <= sm_next;
            for (int i = 0; i < 3; i++)
                sq3_reg[i] <= 62'(sm2_reg[i]) * 62'(sm2_reg[i]);
            sm3_reg  <= sm2_reg;
            sq_s_reg[0]    <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_sm_reg[0]   <= sm3_reg;
        end
    end

    // square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < NSQ; k++)
        begin
            if ({sq_rem_reg[k][RW-3:0], sq_s_reg[k][63:62]} >=
                RW'({sq_root_reg[k], 2'b01}))
            begin
                sq_rem_next[k]  = {sq_rem_reg[k][RW-3:0], sq_s_reg[k][63:62]} -
                                  RW'({sq_root_reg[k], 2'b01});
                sq_root_next[k] = {sq_root_reg[k][30:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = {sq_rem_reg[k][RW-3:0], sq_s_reg[k][63:62]};
                sq_root_next[k] = {sq_root_reg[k][30:0], 1'b0};
            end
            sq_s_next[k] = {sq_s_reg[k][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSQ; k++)
            begin
                sq_s_reg[k+1]    <= sq_s_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_sm_reg[k+1]   <= sq_sm_reg[k];
            end
        end
    end

    // dividend: magnitude times 2^30 plus half the length for rounding
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num[i] = {1'b0, sq_sm_reg[NSQ][i], 30'd0} + 62'(sq_root_reg[NSQ][31:1]);
    end

    // restoring dividers, one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < NDV; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({dv_rem_reg[k][i][DW-2:0], dv_low_reg[k][i][30]} >=
                    DW'(dv_len_reg[k]))
                begin
                    dv_rem_next[k][i] = {dv_rem_reg[k][i][DW-2:0], dv_low_reg[k][i][30]} -
                                        DW'(dv_len_reg[k]);
                    dv_q_next[k][i]   = {dv_q_reg[k][i][29:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k][i] = {dv_rem_reg[k][i][DW-2:0], dv_low_reg[k][i][30]};
                    dv_q_next[k][i]   = {dv_q_reg[k][i][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= DW'(num[i][61:31]);
                dv_low_reg[0][i] <= num[i][30:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0] <= sq_root_reg[NSQ];
            for (int k = 0; k < NDV; k++)
            begin
                dv_rem_reg[k+1] <= dv_rem_next[k];
                dv_q_reg[k+1]   <= dv_q_next[k];
                for (int i = 0; i < 3; i++)
                    dv_low_reg[k+1][i] <= {dv_low_reg[k][i][29:0], 1'b0};
                dv_len_reg[k+1] <= dv_len_reg[k];
            end
        end
    end

    // apply signs
    assign fin_neg = meta_reg[NS-2][3:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= fin_neg[i] ? -$signed({1'b0, dv_q_reg[NDV][i]})
                                         : $signed({1'b0, dv_q_reg[NDV][i]});
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_vec.x = res_reg[0];
    assign out_vec.y = res_reg[1];
    assign out_vec.z = res_reg[2];
    assign out_zero  = meta_reg[NS-1][0];
    assign out_side  = meta_reg[NS-1][MW-1:4];

endmodule

// ===== hw/rtl/lav_cross.sv =====
// two-stage cross product of 32-bit vectors with exact 64-bit result
module lav_cross
    import lav_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  vec32_t        a,
    input  vec32_t        b,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output vec64_t        out_vec,
    output logic [SW-1:0] out_side
);

    logic signed [63:0] prod_reg [6];
    logic [SW-1:0]      side_reg [2];
    logic [1:0]         valid_reg;
    vec64_t             c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[0], in_valid};
    end

    // products, then differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= a.y * b.z;
            prod_reg[1] <= a.z * b.y;
            prod_reg[2] <= a.z * b.x;
            prod_reg[3] <= a.x * b.z;
            prod_reg[4] <= a.x * b.y;
            prod_reg[5] <= a.y * b.x;
            side_reg[0] <= in_side;
            c_reg.x     <= prod_reg[0] - prod_reg[1];
            c_reg.y     <= prod_reg[2] - prod_reg[3];
            c_reg.z     <= prod_reg[4] - prod_reg[5];
            side_reg[1] <= side_reg[0];
        end
    end

    assign out_valid = valid_reg[1];
    assign out_vec   = c_reg;
    assign out_side  = side_reg[1];

endmodule

// ===== hw/rtl/lav_xlate.sv =====
// translation column: minus dot of each axis with eye, rounded and saturated
module lav_xlate
    import lav_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  vec32_t             ax,
    input  vec32_t             ay,
    input  vec32_t             az,
    input  vec32_t             eye,
    input  logic [SW-1:0]      in_side,
    output logic               out_valid,
    output logic signed [33:0] out_tx,
    output logic signed [33:0] out_ty,
    output logic signed [33:0] out_tz,
    output logic [SW-1:0]      out_side
);

    vec32_t             axes [3];
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] dot_reg [3];
    logic signed [33:0] sh_reg [3];
    logic [33:0]        r [3];
    logic signed [33:0] sh_next [3];
    logic [SW-1:0]      side_reg [3];
    logic [2:0]         valid_reg;

    assign axes[0] = ax;
    assign axes[1] = ay;
    assign axes[2] = az;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    // negate, round half away from zero, saturate to 34 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r[i] = round_mag(dot_reg[i]);
            if (!dot_reg[i][63] && dot_reg[i] != '0)
                sh_next[i] = (r[i] > SHIFT_LIM) ? SHIFT_MIN : -$signed(r[i]);
            else
                sh_next[i] = (r[i] > 34'(SHIFT_MAX)) ? SHIFT_MAX : $signed(r[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i][0] <= axes[i].x * eye.x;
                prod_reg[i][1] <= axes[i].y * eye.y;
                prod_reg[i][2] <= axes[i].z * eye.z;
                dot_reg[i]     <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
            end
            sh_reg      <= sh_next;
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
        end
    end

    assign out_valid = valid_reg[2];
    assign out_tx    = sh_reg[0];
    assign out_ty    = sh_reg[1];
    assign out_tz    = sh_reg[2];
    assign out_side  = side_reg[2];

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the look-at view matrix block: stream driver, monitor and matrix predictor
`timescale 1ns / 1ps

module tb;
    import lav_pkg::*;

    localparam int LATENCY   = 150;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic signed [31:0] ax [3][3];
        logic signed [33:0] sh [3];
    } view_mat_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [391:0] m_axis_tdata;

    logic [287:0] setup_q [$];
    view_mat_t    matrix_q [$];
    int           n_err;
    int           idle_cycles;
    bit           stim_done;
    int           gap_left;
    int           stall_left;

    // field names for mismatch reports
    string        ax_name [3][3] = '{'{"right_x", "right_y", "right_z"},
                                     '{"upaxis_x", "upaxis_y", "upaxis_z"},
                                     '{"back_x", "back_y", "back_z"}};
    string        sh_name [3] = '{"right_shift", "upaxis_shift", "back_shift"};

    look_at_view_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // integer square root by bit pairs
    function automatic logic [63:0] sqrt_floor(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= res + b)
                begin
                    s = s - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        end
    endfunction

    // scale to a q30 unit vector, zero on zero length
    function automatic bit unit_vec(input longint v [3], output longint u [3]);
        logic [63:0] mag [3];
        logic [63:0] top;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        begin
            top = 0;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
                if (mag[i] > top)
                    top = mag[i];
            end
            if (top == 0)
                return 1'b0;
            while (top >= 64'd1 << 31)
            begin
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
                top = top >> 1;
            end
            while (top < 64'd1 << 30)
            begin
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
                top = top << 1;
            end
            for (int i = 0; i < 3; i++)
                sum = sum + mag[i] * mag[i];
            len = sqrt_floor(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << 30) + (len >> 1)) / len;
                u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1'b1;
        end
    endfunction

    // divide by 2^30 with rounding half away from zero
    function automatic longint q30_round(input longint v);
        logic [63:0] m;
        longint r;
        begin
            m = v < 0 ? 64'(-v) : 64'(v);
            r = longint'((m + (64'd1 << 29)) >> 30);
            return v < 0 ? -r : r;
        end
    endfunction

    function automatic longint eye_shift(input longint a [3], input longint e [3]);
        longint r;
        begin
            r = q30_round(-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]));
            if (r > 64'sd8589934591)
                r = 64'sd8589934591;
            if (r < -64'sd8589934592)
                r = -64'sd8589934592;
            return r;
        end
    endfunction

    // view matrix for one eye/target/up set-up
    function automatic view_mat_t view_matrix(input logic [287:0] d);
        longint eye [3];
        longint up [3];
        longint dir [3];
        longint crs [3];
        longint xa [3];
        longint ya [3];
        longint za [3];
        longint sh [3];
        view_mat_t m;
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye[i] = longint'($signed(d[32*i +: 32]));
                up[i]  = longint'($signed(d[32*(6+i) +: 32]));
                dir[i] = eye[i] - longint'($signed(d[32*(3+i) +: 32]));
                xa[i] = (i == 0) ? 64'sd1073741824 : 0;
                ya[i] = (i == 1) ? 64'sd1073741824 : 0;
                za[i] = (i == 2) ? 64'sd1073741824 : 0;
                sh[i] = 0;
            end
            if (unit_vec(dir, za))
            begin
                crs[0] = up[1] * za[2] - up[2] * za[1];
                crs[1] = up[2] * za[0] - up[0] * za[2];
                crs[2] = up[0] * za[1] - up[1] * za[0];
                if (unit_vec(crs, xa))
                begin
                    ya[0] = q30_round(za[1] * xa[2] - za[2] * xa[1]);
                    ya[1] = q30_round(za[2] * xa[0] - za[0] * xa[2]);
                    ya[2] = q30_round(za[0] * xa[1] - za[1] * xa[0]);
                    for (int i = 0; i < 3; i++)
                    begin
                        if (ya[i] > 64'sd1073741824)
                            ya[i] = 64'sd1073741824;
                        if (ya[i] < -64'sd1073741824)
                            ya[i] = -64'sd1073741824;
                    end
                    sh[0] = eye_shift(xa, eye);
                    sh[1] = eye_shift(ya, eye);
                    sh[2] = eye_shift(za, eye);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        xa[i] = (i == 0) ? 64'sd1073741824 : 0;
                        za[i] = (i == 2) ? 64'sd1073741824 : 0;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    za[i] = (i == 2) ? 64'sd1073741824 : 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                m.ax[0][i] = xa[i][31:0];
                m.ax[1][i] = ya[i][31:0];
                m.ax[2][i] = za[i][31:0];
                m.sh[i] = sh[i][33:0];
            end
            return m;
        end
    endfunction

    function automatic logic [31:0] rnd_coord(input int mode);
        logic [31:0] v;
        begin
            case (mode)
                0: v = $urandom;
                1: v = 32'($signed($urandom_range(0, 40)) - 20) << 16;
                2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: v = 32'($signed($urandom_range(0, 2000)) - 1000) <<
                             $urandom_range(0, 20);
            endcase
            return v;
        end
    endfunction

    function automatic logic [287:0] pack_setup(input logic [31:0] e [3],
                                                input logic [31:0] t [3],
                                                input logic [31:0] u [3]);
        logic [287:0] d;
        begin
            for (int i = 0; i < 3; i++)
            begin
                d[32*i +: 32]     = e[i];
                d[32*(3+i) +: 32] = t[i];
                d[32*(6+i) +: 32] = u[i];
            end
            return d;
        end
    endfunction

    function automatic int rnd_gap();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    endfunction

    // stimulus
    initial
    begin
        logic [31:0] e [3];
        logic [31:0] t [3];
        logic [31:0] u [3];
        int mode;
        // directed: identity cases, extremes, classic set-ups
        setup_q.push_back('0);
        setup_q.push_back({9{32'h8000_0000}});
        setup_q.push_back({9{32'h7FFF_FFFF}});
        e = '{32'h0, 32'h0, 32'h5_0000}; t = '{0, 0, 0}; u = '{0, 32'h1_0000, 0};
        setup_q.push_back(pack_setup(e, t, u));
        u = '{0, 0, 32'h1_0000};
        setup_q.push_back(pack_setup(e, t, u));
        u = '{0, 0, 0};
        setup_q.push_back(pack_setup(e, t, u));
        e = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        u = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
        setup_q.push_back(pack_setup(e, t, u));
        e = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        u = '{32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        setup_q.push_back(pack_setup(e, t, u));
        e = '{32'h1, 32'h0, 32'h0}; t = '{0, 0, 0}; u = '{0, 32'h1, 0};
        setup_q.push_back(pack_setup(e, t, u));
        e = '{32'h3_0000, 32'h4_0000, 32'h5_0000}; t = '{32'h1_0000, 32'h1_0000, 0};
        u = '{32'hFFFF_0000, 32'h2_0000, 32'h8000};
        setup_q.push_back(pack_setup(e, t, u));
        for (int k = 0; k < 10; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e[i] = rnd_coord(2);
                t[i] = rnd_coord(2);
                u[i] = rnd_coord(2);
            end
            setup_q.push_back(pack_setup(e, t, u));
        end
        // random set-ups, some with degenerate geometry
        for (int k = 0; k < 900; k++)
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++)
            begin
                e[i] = rnd_coord(mode);
                t[i] = rnd_coord(mode);
                u[i] = rnd_coord($urandom_range(0, 3));
            end
            case ($urandom_range(0, 19))
                0: t = e;
                1: u = '{0, 0, 0};
                2: for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
                default: ;
            endcase
            setup_q.push_back(pack_setup(e, t, u));
        end
        stim_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                matrix_q.push_back(view_matrix(s_axis_tdata));
            if (gap_left > 0 || setup_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= setup_q.pop_front();
                gap_left      <= ($urandom_range(0, 3) == 0) ? rnd_gap() : 0;
            end
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= rnd_gap();
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        view_mat_t x;
        logic [391:0] d;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            d = m_axis_tdata;
            if (matrix_q.size() == 0)
            begin
                $error("unexpected matrix transaction");
                n_err++;
            end
            else
            begin
                x = matrix_q.pop_front();
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                        if (d[130*r + 32*c +: 32] !== x.ax[r][c])
                        begin
                            $error("%s: expected %0d actual %0d", ax_name[r][c],
                                   x.ax[r][c], $signed(d[130*r + 32*c +: 32]));
                            n_err++;
                        end
                    if (d[130*r + 96 +: 34] !== x.sh[r])
                    begin
                        $error("%s: expected %0d actual %0d", sh_name[r], x.sh[r],
                               $signed(d[130*r + 96 +: 34]));
                        n_err++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // reset and end of run
    initial
    begin
        n_err       = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && setup_q.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid || matrix_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (n_err == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
